// ===== design/wspe_pkg.sv =====
package wspe_pkg;

  // Register indexes on the configuration channel
  localparam logic [1:0] CfgBrightness = 2'd0;
  localparam logic [1:0] CfgOneDuty    = 2'd1;
  localparam logic [1:0] CfgZeroDuty   = 2'd2;
  localparam logic [1:0] CfgGapCount   = 2'd3;

  // Register reset values
  localparam logic [7:0]  BrightnessRst = 8'd100;
  localparam logic [15:0] OneDutyRst    = 16'd33;
  localparam logic [15:0] ZeroDutyRst   = 16'd17;
  localparam logic [6:0]  GapCountRst   = 7'd50;

  // Scaling and framing constants
  localparam logic [7:0]  PctFull     = 8'd100;
  localparam logic [6:0]  MaxGapSlots = 7'd64;
  localparam logic [6:0]  BitsPerPix  = 7'd24;
  localparam int unsigned WordBits    = 24;

  // floor(p / 100) for p <= 25500 as (p * 5243) >> 19
  localparam logic [27:0] RecipMul   = 28'd5243;
  localparam int unsigned RecipShift = 19;

  typedef struct packed {
    logic       command;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [15:0] duty_value;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  brightness;
    logic [15:0] one_duty;
    logic [15:0] zero_duty;
    logic [6:0]  gap_count;
  } cfg_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic                is_eof;
    logic [WordBits-1:0] word;
  } job_t;

endpackage

// ===== design/wspe_front.sv =====
module wspe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wspe_pkg::cfg_t    cfg_i,
  input  logic              push,
  output logic              full,
  input  wspe_pkg::in_item_t in_data_i,
  output logic              job_push_o,
  input  logic              job_full_i,
  output wspe_pkg::job_t    job_o
);

  logic [6:0]  pct;
  logic [14:0] prod_g, prod_r, prod_b;
  logic        s1_valid_q, s1_valid_d;
  logic        s1_cmd_q;
  logic [14:0] s1_pg_q, s1_pr_q, s1_pb_q;
  logic        accept;
  logic        advance;
  logic [27:0] sc_g, sc_r, sc_b;

  // Saturate brightness at full scale
  assign pct = (cfg_i.brightness > wspe_pkg::PctFull) ? wspe_pkg::PctFull[6:0]
                                                      : cfg_i.brightness[6:0];

  // Multiply each colour by the percentage
  assign prod_g = 15'(in_data_i.green) * 15'(pct);
  assign prod_r = 15'(in_data_i.red) * 15'(pct);
  assign prod_b = 15'(in_data_i.blue) * 15'(pct);

  // Advance the stage when the queue has room
  assign advance    = s1_valid_q && !job_full_i;
  assign full       = s1_valid_q && job_full_i;
  assign accept     = push && !full;
  assign job_push_o = advance;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Hold the products of the accepted request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q <= in_data_i.command;
      s1_pg_q  <= prod_g;
      s1_pr_q  <= prod_r;
      s1_pb_q  <= prod_b;
    end
  end

  // Divide by one hundred through the reciprocal
  assign sc_g = (28'(s1_pg_q) * wspe_pkg::RecipMul) >> wspe_pkg::RecipShift;
  assign sc_r = (28'(s1_pr_q) * wspe_pkg::RecipMul) >> wspe_pkg::RecipShift;
  assign sc_b = (28'(s1_pb_q) * wspe_pkg::RecipMul) >> wspe_pkg::RecipShift;

  assign job_o.is_eof = s1_cmd_q;
  assign job_o.word   = {sc_g[7:0], sc_r[7:0], sc_b[7:0]};

endmodule

// ===== design/wspe_queue.sv =====
module wspe_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wspe_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output wspe_pkg::job_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthC  = CntW'(Depth);

  wspe_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == DepthC);
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/wspe_back.sv =====
module wspe_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wspe_pkg::cfg_t       cfg_i,
  input  logic                 job_valid_i,
  input  wspe_pkg::job_t       job_i,
  output logic                 job_pop_o,
  output logic                 empty,
  input  logic                 pop,
  output wspe_pkg::out_item_t  out_data_o
);

  logic                      active_q, active_d;
  logic                      eof_q;
  logic [wspe_pkg::WordBits-1:0] word_q;
  logic [6:0]                cnt_q;
  logic                      out_valid_q, out_valid_d;
  wspe_pkg::out_item_t       out_q;
  logic                      emit;
  logic                      last;
  logic                      load;
  logic [6:0]                gap_sat;
  logic                      drop;

  // Issue a slot when the output register is free or being taken
  assign emit = active_q && (!out_valid_q || pop);
  assign last = (cnt_q == 7'd1);
  assign load = job_valid_i && (!active_q || (emit && last));
  assign job_pop_o = load;

  assign gap_sat = (cfg_i.gap_count > wspe_pkg::MaxGapSlots) ? wspe_pkg::MaxGapSlots
                                                             : cfg_i.gap_count;
  // An end of frame with an empty gap gives no slot
  assign drop = job_i.is_eof && (gap_sat == '0);

  always_comb begin
    active_d = active_q;
    if (load) begin
      active_d = !drop;
    end else if (emit && last) begin
      active_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load a new request or shift the current one
  always_ff @(posedge clk_i) begin
    if (load) begin
      eof_q  <= job_i.is_eof;
      word_q <= job_i.word;
      cnt_q  <= job_i.is_eof ? gap_sat : wspe_pkg::BitsPerPix;
    end else if (emit) begin
      word_q <= {word_q[wspe_pkg::WordBits-2:0], 1'b0};
      cnt_q  <= cnt_q - 1'b1;
    end
  end

  // Drive the output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.last_of_run <= last;
      if (eof_q) begin
        out_q.duty_value <= '0;
      end else begin
        out_q.duty_value <= word_q[wspe_pkg::WordBits-1] ? cfg_i.one_duty : cfg_i.zero_duty;
      end
    end
  end

  assign empty      = !out_valid_q;
  assign out_data_o = out_q;

endmodule

// ===== design/ws2812_pixel_pwm_encoder_core.sv =====
// WS2812 pixel PWM encoder.
// Input queue side: drive in_data_i and raise push; a request is taken at a
// clock edge with push high and full low. A request is a pixel (green, red,
// blue) or an end-of-frame command (colours ignored).
// Result queue side: while empty is low the oldest slot is on out_data_o;
// raise pop to take it. A pixel yields 24 duty slots, MSB of the scaled
// G:R:B word first; end of frame yields min(gap_count, 64) zero
// slots, or none when that count is zero. last_of_run marks a run's end.
// A taken request passes the front stage register, the job queue, the
// back-end shift register and the output register. One slot per cycle
// while pop keeps taking slots; the next pixel streams right after the last.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high; write only while the block is idle.
// Reset clears the queues and restores brightness 100, duties 33 and 17 and
// a 50-slot gap. When the receiver stalls, the slot holds, the job queue
// fills, and full rises to stall the sender; nothing is dropped.
module ws2812_pixel_pwm_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  wspe_pkg::in_item_t  in_data_i,
  output logic                empty,
  input  logic                pop,
  output wspe_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  wspe_pkg::cfg_t cfg_q;
  wspe_pkg::job_t front_job, back_job;
  logic           job_push, job_full, job_valid, job_pop;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness <= wspe_pkg::BrightnessRst;
      cfg_q.one_duty   <= wspe_pkg::OneDutyRst;
      cfg_q.zero_duty  <= wspe_pkg::ZeroDutyRst;
      cfg_q.gap_count  <= wspe_pkg::GapCountRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        wspe_pkg::CfgBrightness: cfg_q.brightness <= cfg_data_i[7:0];
        wspe_pkg::CfgOneDuty:    cfg_q.one_duty   <= cfg_data_i;
        wspe_pkg::CfgZeroDuty:   cfg_q.zero_duty  <= cfg_data_i;
        wspe_pkg::CfgGapCount:   cfg_q.gap_count  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  wspe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .job_push_o (job_push),
    .job_full_i (job_full),
    .job_o      (front_job)
  );

  wspe_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (front_job),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .data_o  (back_job)
  );

  wspe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (back_job),
    .job_pop_o   (job_pop),
    .empty       (empty),
    .pop         (pop),
    .out_data_o  (out_data_o)
  );

endmodule
